// ===== rtl/ssl_pkg.sv =====
`default_nettype none

package ssl_pkg;

  localparam int POS_W  = 11;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;    // compare every entry against the key
    logic shift;  // move the scan word one cell toward cell 0
    logic ins;    // open a slot and drop the key into it
  } cell_ctl_t;

  // Scan word handed from cell to cell.
  typedef struct packed {
    logic lt;
    logic eq;
  } scan_t;

endpackage

`default_nettype wire

// ===== rtl/ssl_cell.sv =====
`default_nettype none

module ssl_cell #(
  parameter int KEY_W = 32,
  parameter int CNT_W = 11,
  parameter int IDX   = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ssl_pkg::cell_ctl_t ctl,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [CNT_W-1:0]  fill,
  input  wire logic [KEY_W-1:0]  prev_value,
  input  wire logic              prev_lt,
  input  wire ssl_pkg::scan_t    scan_in,
  output logic [KEY_W-1:0]       value,
  output logic                   lt,
  output ssl_pkg::scan_t         scan_out
);

  logic [KEY_W-1:0] val_r;
  logic             lt_r;
  logic             lt_nxt;
  logic             eq_nxt;
  logic             used;
  ssl_pkg::scan_t   scan_r;

  assign used   = fill > CNT_W'(IDX);
  assign lt_nxt = used && (val_r < key);
  assign eq_nxt = used && (val_r == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r   <= 1'b0;
      scan_r <= '0;
    end else if (ctl.cmp) begin
      lt_r      <= lt_nxt;
      scan_r.lt <= lt_nxt;
      scan_r.eq <= eq_nxt;
    end else if (ctl.shift) begin
      scan_r <= scan_in;
    end
  end

  // Entries at or above the insert point move up one slot; the first one takes the key.
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt_r) begin
      val_r <= prev_lt ? key : prev_value;
    end
  end

  assign value    = val_r;
  assign lt       = lt_r;
  assign scan_out = scan_r;

endmodule

`default_nettype wire

// ===== rtl/sorted_set_lower_bound_core.sv =====
`default_nettype none

// Channel  | ports                             | handshake
// ---------+-----------------------------------+------------------------------
// input    | in_op, in_value                   | start && !busy
// result   | out_position, out_status          | out_valid, one cycle, no stall
//
// An item holds busy through one compare across all cells, then the compare
// word walks the cell chain one cell per cycle until the first entry not below
// the value reaches cell 0, or until all CAPACITY entries are found below it.
// The result shows in the first cycle that busy is low. Reset empties the
// table at once. The receiver cannot stall.

module sorted_set_lower_bound_core #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_op,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              out_valid,
  output logic [ssl_pkg::POS_W-1:0]         out_position,
  output logic [ssl_pkg::STAT_W-1:0]        out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic                        op_r;
  logic [VALUE_BITS-1:0]       key_r;
  logic [CNT_W-1:0]            fill_r, fill_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ssl_pkg::POS_W-1:0]   out_position_r, out_position_nxt;
  logic [ssl_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  ssl_pkg::cell_ctl_t          ctl;
  logic                        done;
  logic                        dup;
  logic [CNT_W-1:0]            pos;
  logic [CNT_W-1:0]            res_cnt;
  logic [CNT_W+ssl_pkg::POS_W-1:0] res_wide;

  logic [VALUE_BITS-1:0] val_w [CAPACITY];
  logic                  lt_w  [CAPACITY];
  ssl_pkg::scan_t        scan_w[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssl_pkg::scan_t        scan_in;
    logic [VALUE_BITS-1:0] prev_value;
    logic                  prev_lt;

    if (i == 0) begin : g_head
      assign prev_value = key_r;
      assign prev_lt    = 1'b1;
    end else begin : g_body
      assign prev_value = val_w[i-1];
      assign prev_lt    = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign scan_in = '0;
    end else begin : g_link
      assign scan_in = scan_w[i+1];
    end

    ssl_cell #(
      .KEY_W (VALUE_BITS),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (key_r),
      .fill       (fill_r),
      .prev_value (prev_value),
      .prev_lt    (prev_lt),
      .scan_in    (scan_in),
      .value      (val_w[i]),
      .lt         (lt_w[i]),
      .scan_out   (scan_w[i])
    );
  end

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    fill_nxt         = fill_r;
    out_valid_nxt    = 1'b0;
    out_position_nxt = out_position_r;
    out_status_nxt   = out_status_r;
    ctl              = '0;
    done             = 1'b0;
    dup              = 1'b0;
    pos              = idx_r;
    res_cnt          = idx_r;
    res_wide         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp   = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_w[0].lt) begin
          done = 1'b1;
          dup  = scan_w[0].eq;
          pos  = idx_r;
        end else if (idx_r == CNT_W'(CAPACITY - 1)) begin
          done = 1'b1;
          pos  = CNT_W'(CAPACITY);
        end else begin
          ctl.shift = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      state_nxt      = ST_IDLE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = ssl_pkg::STATUS_OK;
      res_cnt        = pos;
      if (!op_r) begin
        if (dup) begin
          out_status_nxt = ssl_pkg::STATUS_DUP;
          res_cnt        = fill_r;
        end else if (fill_r >= CNT_W'(CAPACITY)) begin
          out_status_nxt = ssl_pkg::STATUS_FULL;
          res_cnt        = fill_r;
        end else begin
          ctl.ins  = 1'b1;
          fill_nxt = fill_r + 1'b1;
          res_cnt  = fill_nxt;
        end
      end
      res_wide         = {{ssl_pkg::POS_W{1'b0}}, res_cnt};
      out_position_nxt = res_wide[ssl_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r  <= in_op;
      // sign bit flipped so an unsigned compare orders signed values
      key_r <= in_value ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
    end
    out_position_r <= out_position_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign busy         = state_r != ST_IDLE;
  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/ssl_chk.sv =====
`default_nettype none

module ssl_chk #(
  parameter int VALUE_BITS = 32
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         in_op,
  input wire logic signed [VALUE_BITS-1:0] in_value,
  input wire logic                         out_valid,
  input wire logic [ssl_pkg::POS_W-1:0]    out_position,
  input wire logic [ssl_pkg::STAT_W-1:0]   out_status
);

  // every accepted word ends with exactly one result as the block goes idle
  a_fall_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  a_result_only_after_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result without a finished word");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted word did not start work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ssl_pkg::STATUS_OK || out_status == ssl_pkg::STATUS_DUP
      || out_status == ssl_pkg::STATUS_FULL)
    else $error("bad status code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

  // in_op, in_value and out_position are checked by no assertion here; this sink keeps them used
  logic unused_ok;
  assign unused_ok = in_op ^ (^in_value) ^ (^out_position);

endmodule

bind sorted_set_lower_bound_core ssl_chk #(
  .VALUE_BITS (VALUE_BITS)
) u_ssl_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_op        (in_op),
  .in_value     (in_value),
  .out_valid    (out_valid),
  .out_position (out_position),
  .out_status   (out_status)
);

`default_nettype wire

// ===== sim/lower_bound_tb_pkg.sv =====
`timescale 1ns / 100ps

package lower_bound_tb_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

// ===== sim/lower_bound_monitor.sv =====
`timescale 1ns / 100ps

module lower_bound_monitor #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          in_op,
  input  wire logic signed [VALUE_BITS-1:0]  in_value,
  input  wire logic                          out_valid,
  input  wire logic [ssl_pkg::POS_W-1:0]     out_position,
  input  wire logic [ssl_pkg::STAT_W-1:0]    out_status,
  output int                                 mismatch_count,
  output int                                 words_pending
);

  typedef struct packed {
    logic [ssl_pkg::POS_W-1:0]  position;
    logic [ssl_pkg::STAT_W-1:0] status;
  } set_answer_t;

  // shadow copy of the table, ascending
  logic signed [VALUE_BITS-1:0] set_model [CAPACITY];
  int unsigned set_size = 0;
  set_answer_t answer_q [$];
  int errors = 0;

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
  end

  function automatic int unsigned count_below(logic signed [VALUE_BITS-1:0] bound);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = set_size;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (set_model[mid] < bound) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // updates the shadow table and returns the answer word the block owes
  function automatic set_answer_t predict_answer(logic op,
                                                 logic signed [VALUE_BITS-1:0] value);
    set_answer_t ans;
    int unsigned slot;
    slot = count_below(value);
    ans.status = ssl_pkg::STATUS_OK;
    if (op == lower_bound_tb_pkg::OP_INSERT) begin
      // duplicate wins over full
      if (slot < set_size && set_model[slot] == value) begin
        ans.status = ssl_pkg::STATUS_DUP;
      end else if (set_size >= CAPACITY) begin
        ans.status = ssl_pkg::STATUS_FULL;
      end else begin
        for (int unsigned i = set_size; i > slot; i--) set_model[i] = set_model[i - 1];
        set_model[slot] = value;
        set_size++;
      end
      slot = set_size;
    end
    ans.position = slot[ssl_pkg::POS_W-1:0];
    return ans;
  endfunction

  always @(posedge clk) begin
    set_answer_t want;
    if (!rst_n) begin
      set_size = 0;
      answer_q.delete();
    end else begin
      // result leaves before a new word enters on the same edge
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected: position %0d status %0d",
                   $time, out_position, out_status);
        end else begin
          want = answer_q.pop_front();
          if (out_position !== want.position) begin
            errors++;
            $display("%0t: position mismatch: expected %0d, actual %0d",
                     $time, want.position, out_position);
          end
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
        end
      end
      if (start && !busy) begin
        answer_q.insert(answer_q.size(), predict_answer(in_op, in_value));
      end
    end
    mismatch_count <= errors;
    words_pending  <= answer_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int IDLE_LIMIT = 10000;
  localparam int FILL_WORDS = 200;
  localparam logic signed [VALUE_BITS-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_BITS-1:0] V_MAX = 32'sh7fff_ffff;

  logic                          clk      = 1'b0;
  logic                          rst_n    = 1'b0;
  logic                          start    = 1'b0;
  logic                          in_op    = lower_bound_tb_pkg::OP_INSERT;
  logic signed [VALUE_BITS-1:0]  in_value = '0;
  logic                          busy;
  logic                          out_valid;
  logic [ssl_pkg::POS_W-1:0]     out_position;
  logic [ssl_pkg::STAT_W-1:0]    out_status;
  int                            mismatch_count;
  int                            words_pending;
  int                            idle_cycles = 0;
  int                            calm_words  = 0;
  logic signed [VALUE_BITS-1:0]  sent_values [$];

  logic signed [VALUE_BITS-1:0] corner_vals [5] = '{0, V_MIN, V_MAX, -1, 1};
  logic signed [VALUE_BITS-1:0] probe_vals  [9] =
    '{V_MIN, V_MIN + 1, -2, -1, 0, 1, 2, V_MAX - 1, V_MAX};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_set_lower_bound_core #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_position (out_position),
    .out_status   (out_status)
  );

  lower_bound_monitor #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_position   (out_position),
    .out_status     (out_status),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called just after a rising edge; returns after the edge that takes the word, once busy is low
  task automatic send_word(input logic op, input logic signed [VALUE_BITS-1:0] value);
    int gap;
    if (calm_words > 0) begin
      calm_words--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm_words = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == lower_bound_tb_pkg::OP_INSERT) sent_values.insert(sent_values.size(), value);
  endtask

  // small values, corners, neighbors of earlier inserts, or anything
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = int'($urandom_range(0, 63)) - 32;
      2: v = corner_vals[$urandom_range(0, 4)];
      3, 4, 5: begin
        if (sent_values.size() == 0) begin
          v = $urandom;
        end else begin
          v = sent_values[$urandom_range(0, sent_values.size() - 1)];
          case ($urandom_range(0, 3))
            0: v = v - 1;
            1: v = v + 1;
            default: ;
          endcase
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic random_words(input int count, input int insert_pct);
    logic op;
    repeat (count) begin
      op = ($urandom_range(0, 99) < insert_pct) ? lower_bound_tb_pkg::OP_INSERT
                                                 : lower_bound_tb_pkg::OP_QUERY;
      send_word(op, pick_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table
    send_word(lower_bound_tb_pkg::OP_QUERY, 0);
    send_word(lower_bound_tb_pkg::OP_QUERY, V_MIN);
    send_word(lower_bound_tb_pkg::OP_QUERY, V_MAX);
    foreach (corner_vals[i]) send_word(lower_bound_tb_pkg::OP_INSERT, corner_vals[i]);
    send_word(lower_bound_tb_pkg::OP_INSERT, 0);
    send_word(lower_bound_tb_pkg::OP_INSERT, V_MAX);
    send_word(lower_bound_tb_pkg::OP_INSERT, V_MIN);
    send_word(lower_bound_tb_pkg::OP_INSERT, -1);
    foreach (probe_vals[i]) send_word(lower_bound_tb_pkg::OP_QUERY, probe_vals[i]);

    random_words(240, 40);

    // descending run keeps each insert short and grows the table quickly
    for (int k = 0; k < FILL_WORDS; k++) begin
      send_word(lower_bound_tb_pkg::OP_INSERT, V_MIN + 30000 - k);
    end

    // larger table: duplicates and long searches
    random_words(120, 50);

    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ssl_pkg.sv
rtl/ssl_cell.sv
rtl/sorted_set_lower_bound_core.sv
rtl/ssl_chk.sv
sim/lower_bound_tb_pkg.sv
sim/lower_bound_monitor.sv
sim/tb_top.sv
